@@ hdl/apc_pkg.sv @@
package apc_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int COUNT_OUT_W = 13;

  // shared multiplier: wide operand / product, narrow serial operand
  localparam int MUL_A_W = 160;
  localparam int MUL_B_W = 64;
  localparam int TERM_W = 64;
  localparam int DEN_W = 128;
  localparam int Q_W = 16;
  localparam int QSQ_W = 32;
  localparam int NUM_SHIFT = 30;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [15:0] CORR_ONE = 16'd32768;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic last;
  } in_t;

  typedef struct packed {
    logic [15:0] correlation;
    logic [1:0] status;
    logic [COUNT_OUT_W-1:0] point_count;
  } out_t;

endpackage

@@ hdl/abs_pearson_correlation_top.sv @@
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o   | apc_pkg::in_t  (x, y, last)
// out     | output    | out_valid_o / out_stall_i | apc_pkg::out_t (correlation, status, point_count)
//
// Points accumulate at one per cycle while in_stall_o is low. A point marked last
// starts the final evaluation on one shared shift-add multiplier: eight products
// for the terms, then a 16-step bit search, each step two products. Each product
// runs until its serial operand has no ones left; in_stall_o is high throughout.
// Reset clears the sums and the sequencer. A stalled result waits in the
// output register while the next set accumulates.
module abs_pearson_correlation_top #(
  parameter int MAX_POINTS = apc_pkg::MAX_POINTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  apc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output apc_pkg::out_t out_data_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = apc_pkg::COORD_BITS + CNT_W;
  localparam int SQ_W = 2 * apc_pkg::COORD_BITS + CNT_W;
  localparam int AW = apc_pkg::MUL_A_W;
  localparam int BW = apc_pkg::MUL_B_W;
  localparam int TW = apc_pkg::TERM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_COV1, S_COV2, S_DX1, S_DX2, S_DY1, S_DY2,
    S_DEN, S_NUM, S_SQ, S_TST, S_FIN
  } state_e;

  state_e state_q;
  logic   busy_q, mul_start_q, degen_q;
  logic   out_valid_q;
  apc_pkg::out_t out_q;

  logic [TW-1:0]             t_q, nabs_q, dx_q, dy_q;
  logic [apc_pkg::DEN_W-1:0] den_q;
  logic [AW-1:0]             num_q;
  logic [apc_pkg::QSQ_W-1:0] csq_q;
  logic [apc_pkg::Q_W-1:0]   q_q;
  logic [3:0]                k_q;

  logic [CNT_W-1:0]        n;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [SQ_W-1:0]  sxx, syy, sxy;
  logic                    ovf;

  logic          in_acc, clear, load_out, mul_done;
  logic [AW-1:0] mul_a, mul_p;
  logic [BW-1:0] mul_b;
  logic [TW-1:0] diff;
  logic [apc_pkg::Q_W-1:0] cand;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign clear      = load_out;
  assign diff       = t_q - mul_p[TW-1:0];
  assign cand       = q_q | (apc_pkg::Q_W'(1) << k_q);

  apc_accum #(
    .MAX_POINTS(MAX_POINTS)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (in_acc),
    .clear_i (clear),
    .x_i     (in_data_i.x),
    .y_i     (in_data_i.y),
    .count_o (n),
    .sx_o    (sx),
    .sy_o    (sy),
    .sxx_o   (sxx),
    .syy_o   (syy),
    .sxy_o   (sxy),
    .ovf_o   (ovf)
  );

  // operands, two's complement where signed; term arithmetic is mod 2^64
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_COV1: begin mul_a = AW'(n);   mul_b = BW'(sxy); end
      S_COV2: begin mul_a = AW'(sx);  mul_b = BW'(sy);  end
      S_DX1:  begin mul_a = AW'(n);   mul_b = BW'(sxx); end
      S_DX2:  begin mul_a = AW'(sx);  mul_b = BW'(sx);  end
      S_DY1:  begin mul_a = AW'(n);   mul_b = BW'(syy); end
      S_DY2:  begin mul_a = AW'(sy);  mul_b = BW'(sy);  end
      S_DEN:  begin mul_a = AW'(dx_q); mul_b = dy_q; end
      S_NUM:  begin mul_a = AW'(nabs_q); mul_b = nabs_q; end
      S_SQ:   begin mul_a = AW'(cand); mul_b = BW'(cand); end
      S_TST:  begin mul_a = AW'(den_q); mul_b = BW'(csq_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  apc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      mul_start_q <= 1'b0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      t_q         <= '0;
      nabs_q      <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      den_q       <= '0;
      num_q       <= '0;
      csq_q       <= '0;
      q_q         <= '0;
      k_q         <= '0;
    end else begin
      mul_start_q <= (state_q != S_IDLE) && (state_q != S_FIN) && !busy_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q != S_IDLE && state_q != S_FIN) begin
        if (!busy_q) begin
          busy_q <= 1'b1;
        end else if (mul_done) begin
          busy_q <= 1'b0;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.last) begin
            state_q <= S_COV1;
          end
        end
        S_COV1: if (busy_q && mul_done) begin
          t_q     <= mul_p[TW-1:0];
          state_q <= S_COV2;
        end
        S_COV2: if (busy_q && mul_done) begin
          nabs_q  <= diff[TW-1] ? (TW'(0) - diff) : diff;
          state_q <= S_DX1;
        end
        S_DX1: if (busy_q && mul_done) begin
          t_q     <= mul_p[TW-1:0];
          state_q <= S_DX2;
        end
        S_DX2: if (busy_q && mul_done) begin
          dx_q    <= diff;
          state_q <= S_DY1;
        end
        S_DY1: if (busy_q && mul_done) begin
          t_q     <= mul_p[TW-1:0];
          state_q <= S_DY2;
        end
        S_DY2: if (busy_q && mul_done) begin
          dy_q <= diff;
          q_q  <= '0;
          k_q  <= 4'(apc_pkg::Q_W - 1);
          if (dx_q == '0 || diff == '0) begin
            degen_q <= 1'b1;
            state_q <= S_FIN;
          end else begin
            degen_q <= 1'b0;
            state_q <= S_DEN;
          end
        end
        S_DEN: if (busy_q && mul_done) begin
          den_q   <= mul_p[apc_pkg::DEN_W-1:0];
          state_q <= S_NUM;
        end
        S_NUM: if (busy_q && mul_done) begin
          num_q   <= {mul_p[AW-apc_pkg::NUM_SHIFT-1:0], apc_pkg::NUM_SHIFT'(0)};
          state_q <= S_SQ;
        end
        S_SQ: if (busy_q && mul_done) begin
          csq_q   <= mul_p[apc_pkg::QSQ_W-1:0];
          state_q <= S_TST;
        end
        // keep the candidate bit when cand^2 * Dx * Dy <= 2^30 * N^2
        S_TST: if (busy_q && mul_done) begin
          if (mul_p <= num_q) begin
            q_q <= cand;
          end
          if (k_q == '0) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= S_SQ;
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_q.correlation <= q_q;
            out_q.status      <= ovf ? apc_pkg::ST_OVF :
                                 (degen_q ? apc_pkg::ST_DEGEN : apc_pkg::ST_OK);
            out_q.point_count <= apc_pkg::COUNT_OUT_W'(n);
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.correlation <= apc_pkg::CORR_ONE)
    else $error("correlation above 1.0");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == apc_pkg::ST_DEGEN) |->
      out_data_o.correlation == '0)
    else $error("degenerate result with nonzero correlation");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last) |=> in_stall_o)
    else $error("input not stalled after last point");

endmodule

@@ hdl/apc_mul.sv @@
// Shift-add multiplier: one conditional add per cycle, stops once b runs out of ones.
module apc_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [apc_pkg::MUL_A_W-1:0]  a_i,
  input  logic [apc_pkg::MUL_B_W-1:0]  b_i,
  output logic                         done_o,
  output logic [apc_pkg::MUL_A_W-1:0]  prod_o
);

  logic                        run_q;
  logic [apc_pkg::MUL_A_W-1:0] acc_q;
  logic [apc_pkg::MUL_A_W-1:0] a_q;
  logic [apc_pkg::MUL_B_W-1:0] b_q;

  assign done_o = run_q && (b_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

@@ hdl/apc_accum.sv @@
module apc_accum #(
  parameter int MAX_POINTS = apc_pkg::MAX_POINTS_DEF,
  parameter int CNT_W = $clog2(MAX_POINTS + 1),
  parameter int SUM_W = apc_pkg::COORD_BITS + CNT_W,
  parameter int SQ_W = 2 * apc_pkg::COORD_BITS + CNT_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                add_i,
  input  logic                                clear_i,
  input  logic signed [apc_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [apc_pkg::COORD_BITS-1:0] y_i,
  output logic [CNT_W-1:0]                    count_o,
  output logic signed [SUM_W-1:0]             sx_o,
  output logic signed [SUM_W-1:0]             sy_o,
  output logic signed [SQ_W-1:0]              sxx_o,
  output logic signed [SQ_W-1:0]              syy_o,
  output logic signed [SQ_W-1:0]              sxy_o,
  output logic                                ovf_o
);

  localparam int PW = 2 * apc_pkg::COORD_BITS;

  logic [CNT_W-1:0]        count_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic signed [SQ_W-1:0]  sxx_q, syy_q, sxy_q;
  logic                    ovf_q;
  logic signed [PW-1:0]    xx, yy, xy;

  assign xx = x_i * x_i;
  assign yy = y_i * y_i;
  assign xy = x_i * y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (clear_i) begin
      count_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (add_i) begin
      if (count_q < CNT_W'(MAX_POINTS)) begin
        count_q <= count_q + 1'b1;
        sx_q    <= sx_q + SUM_W'(x_i);
        sy_q    <= sy_q + SUM_W'(y_i);
        sxx_q   <= sxx_q + SQ_W'(xx);
        syy_q   <= syy_q + SQ_W'(yy);
        sxy_q   <= sxy_q + SQ_W'(xy);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  assign count_o = count_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign sxx_o   = sxx_q;
  assign syy_o   = syy_q;
  assign sxy_o   = sxy_q;
  assign ovf_o   = ovf_q;

endmodule
